/* src/rbf_pkg.sv */
// shared types and constants for the rbf kernel evaluator
// no dependencies
package rbf_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned RegW     = 24;
  localparam int unsigned SumW     = 40;
  localparam int unsigned ExpW     = 17;
  localparam int unsigned FracW    = 20;
  localparam int unsigned KernelW  = 25;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;

  localparam int unsigned DefExpTableDepth = 256;

  localparam logic [CfgIdxW-1:0] RegSignalScale  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNoiseLevel   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInverseWidth = 2'd2;

  localparam logic [RegW-1:0] ResetSignalScale  = 24'd65536;
  localparam logic [RegW-1:0] ResetNoiseLevel   = 24'd0;
  localparam logic [RegW-1:0] ResetInverseWidth = 24'd65536;

  // datapath step strobes, at most one per cycle
  typedef struct packed {
    logic capture;
    logic square;
    logic accum;
    logic mul;
    logic arg;
    logic index;
    logic rom;
    logic interp;
    logic expo;
    logic scale;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

/* src/rbf_ctrl.sv */
// step sequencer for the rbf kernel evaluator
// depends on rbf_pkg
module rbf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rbf_pkg::dp_status_t status_i,
  output rbf_pkg::dp_cmd_t    cmd_o
);
  import rbf_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_ARG  = 4'd4;
  localparam logic [3:0] S_IDX  = 4'd5;
  localparam logic [3:0] S_ROM  = 4'd6;
  localparam logic [3:0] S_INT  = 4'd7;
  localparam logic [3:0] S_EXP  = 4'd8;
  localparam logic [3:0] S_SCL  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = accept;
        if (accept) state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.square = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = status_i.last ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ARG;
      end
      S_ARG: begin
        cmd_o.arg = 1'b1;
        state_d   = S_IDX;
      end
      S_IDX: begin
        cmd_o.index = 1'b1;
        state_d     = S_ROM;
      end
      S_ROM: begin
        cmd_o.rom = 1'b1;
        state_d   = S_INT;
      end
      S_INT: begin
        cmd_o.interp = 1'b1;
        state_d      = S_EXP;
      end
      S_EXP: begin
        cmd_o.expo = 1'b1;
        state_d    = S_SCL;
      end
      S_SCL: begin
        cmd_o.scale = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        cmd_o.emit = status_i.out_free;
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("result loaded while output register busy");

  a_mid_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && !status_i.last) |=> state_q == S_IDLE)
    else $error("non-final item did not return to idle");

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath step at once");

endmodule

/* src/rbf_datapath.sv */
// registers, arithmetic and exponential table of the rbf kernel evaluator
// depends on rbf_pkg
module rbf_datapath #(
  parameter int unsigned ExpTableDepth = rbf_pkg::DefExpTableDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rbf_pkg::dp_cmd_t              cmd_i,
  output rbf_pkg::dp_status_t           status_o,
  input  logic signed [rbf_pkg::CoordW-1:0] coord_left_i,
  input  logic signed [rbf_pkg::CoordW-1:0] coord_right_i,
  input  logic                          last_coord_i,
  input  logic                          on_diagonal_i,
  input  logic                          cfg_we_i,
  input  logic [rbf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rbf_pkg::RegW-1:0]      cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rbf_pkg::KernelW-1:0]   kernel_value_o
);
  import rbf_pkg::*;

  localparam int unsigned AW   = $clog2(ExpTableDepth + 1);
  localparam int unsigned PW   = FracW + AW;
  localparam int unsigned HalfW = SumW / 2;

  typedef logic [ExpW-1:0] rom_t [ExpTableDepth+1];

  // table of exp(-k*16/depth), built by repeated multiplication in q2.30
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] step, sum, term, cur, ratio;
    step = (64'd16 << 30) / 64'(ExpTableDepth);
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n < 24; n++) begin
      term = (term * step) >> 30;
      term = term / 64'(n);
      if (n % 2 == 1) sum = (sum >= term) ? sum - term : 64'd0;
      else            sum = sum + term;
    end
    ratio = sum;
    cur   = 64'd1 << 30;
    for (int k = 0; k <= int'(ExpTableDepth); k++) begin
      r[k] = ExpW'((cur + (64'd1 << 13)) >> 14);
      cur  = (cur * ratio + (64'd1 << 29)) >> 30;
    end
    return r;
  endfunction

  localparam rom_t ExpRom = build_rom();

  logic [RegW-1:0]    scale_q, noise_q, iw_q;
  logic [CoordW-1:0]  ad_q;
  logic               last_q, diag_q;
  logic [2*CoordW-1:0] sq_q;
  logic [SumW-1:0]    sum_q;
  logic [RegW+HalfW-1:0] plo_q, phi_q;
  logic [FracW-1:0]   x_q;
  logic               big_q, zero_q;
  logic [PW-1:0]      p_q;
  logic [ExpW-1:0]    t0_q, t1_q, e_q;
  logic [ExpW+FracW-1:0] dprod_q;
  logic [RegW+ExpW-1:0]  sprod_q;
  logic [KernelW-1:0] out_q;
  logic               out_valid_q;

  logic signed [CoordW:0] diff;
  logic [CoordW:0]        absd;
  logic [SumW:0]          sum_ext;
  logic [63:0]            full;
  logic [PW-1:0]          p_d;
  logic [AW-1:0]          idx;
  logic [AW-1:0]          rd_addr;
  logic [ExpW-1:0]        t1c;
  logic [RegW+ExpW:0]     rounded;
  logic [KernelW:0]       val;

  assign diff    = {coord_left_i[CoordW-1], coord_left_i}
                 - {coord_right_i[CoordW-1], coord_right_i};
  assign absd    = diff[CoordW] ? (CoordW+1)'(-diff) : (CoordW+1)'(diff);
  assign sum_ext = {1'b0, sum_q} + (SumW+1)'(sq_q);
  assign full    = (64'(phi_q) << HalfW) + 64'(plo_q);
  assign p_d     = PW'(x_q) * PW'(ExpTableDepth);
  assign idx     = p_q[PW-1:FracW];
  assign rd_addr = zero_q ? '0 : idx;
  assign t1c     = (t1_q > t0_q) ? t0_q : t1_q;
  assign rounded = (RegW+ExpW+1)'(sprod_q) + (RegW+ExpW+1)'(32768);
  assign val     = (KernelW+1)'(rounded[RegW+ExpW:16])
                 + (diag_q ? (KernelW+1)'(noise_q) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= ResetSignalScale;
      noise_q     <= ResetNoiseLevel;
      iw_q        <= ResetInverseWidth;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegSignalScale:  scale_q <= cfg_data_i;
          RegNoiseLevel:   noise_q <= cfg_data_i;
          RegInverseWidth: iw_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accum) sum_q <= sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
      if (cmd_i.emit) begin
        sum_q       <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ad_q   <= absd[CoordW-1:0];
      last_q <= last_coord_i;
      diag_q <= on_diagonal_i;
    end
    if (cmd_i.square) sq_q <= ad_q * ad_q;
    if (cmd_i.mul) begin
      plo_q <= iw_q * sum_q[HalfW-1:0];
      phi_q <= iw_q * sum_q[SumW-1:HalfW];
    end
    if (cmd_i.arg) begin
      x_q   <= full[FracW+16:17];
      big_q <= |full[63:FracW+17];
    end
    if (cmd_i.index) begin
      p_q    <= p_d;
      zero_q <= big_q || (p_d[PW-1:FracW] >= AW'(ExpTableDepth));
    end
    if (cmd_i.rom) begin
      t0_q <= ExpRom[rd_addr];
      t1_q <= ExpRom[rd_addr + AW'(1)];
    end
    if (cmd_i.interp) dprod_q <= (t0_q - t1c) * p_q[FracW-1:0];
    if (cmd_i.expo)   e_q <= zero_q ? '0 : t0_q - dprod_q[ExpW+FracW-1:FracW];
    if (cmd_i.scale)  sprod_q <= scale_q * e_q;
    if (cmd_i.emit)   out_q <= val[KernelW] ? '1 : val[KernelW-1:0];
  end

  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign kernel_value_o    = out_q;

endmodule

/* src/rbf_kernel_evaluator_top.sv */
// top level of the gaussian rbf kernel evaluator
// depends on rbf_pkg, rbf_ctrl, rbf_datapath
//
// Computes one gaussian kernel matrix entry from a stream of coordinate pairs.
// Each item carries one q8.8 coordinate of the left and right point; the squared
// difference is summed (saturating at 2^40-1). On the item with tlast set the
// block emits scale * exp(-0.5 * inverse_width * distance), plus the noise level
// when tuser (on diagonal) is set, as an unsigned q9.16 value saturating at
// 2^25-1, and clears the sum. The exponential comes from a constant table of
// EXP_TABLE_DEPTH+1 entries over [0, 16) with linear interpolation; arguments of
// 16 or more give zero. The step sequencer drives one shared datapath step per
// cycle unless waiting for input or a free output register: a non-final item is
// accepted, squared and accumulated; a final item goes on through mul, arg,
// index, rom, interp, expo, scale and emit. The next item is taken while a
// result still waits in the output register. Configuration writes are taken at
// any time but should only come while the block is idle.
module rbf_kernel_evaluator_top #(
  parameter int unsigned EXP_TABLE_DEPTH = rbf_pkg::DefExpTableDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [rbf_pkg::InDataW-1:0]    s_axis_tdata_i,  // coord_left, coord_right
  input  logic                           s_axis_tlast_i,  // last_coord
  input  logic                           s_axis_tuser_i,  // on_diagonal
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [rbf_pkg::OutDataW-1:0]   m_axis_tdata_o,  // kernel_value, zero fill
  input  logic                           cfg_we_i,
  input  logic [rbf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rbf_pkg::RegW-1:0]       cfg_data_i
);
  import rbf_pkg::*;

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [KernelW-1:0] kernel_value;

  rbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rbf_datapath #(
    .ExpTableDepth (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .coord_left_i   (s_axis_tdata_i[CoordW-1:0]),
    .coord_right_i  (s_axis_tdata_i[2*CoordW-1:CoordW]),
    .last_coord_i   (s_axis_tlast_i),
    .on_diagonal_i  (s_axis_tuser_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .kernel_value_o (kernel_value)
  );

  // zero fill above the result field
  assign m_axis_tdata_o = OutDataW'(kernel_value);

endmodule
